### rtl/rti_pkg.sv
package rti_pkg;

	localparam int FRAC_BITS = 16;
	localparam int EPS_LSB   = 7;
	localparam int NUM_REGS  = 6;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_START_X = 3'd0;
	localparam reg_idx_t REG_START_Y = 3'd1;
	localparam reg_idx_t REG_START_Z = 3'd2;
	localparam reg_idx_t REG_END_X   = 3'd3;
	localparam reg_idx_t REG_END_Y   = 3'd4;
	localparam reg_idx_t REG_END_Z   = 3'd5;

	typedef struct packed {
		logic valid;
		logic miss;
		logic sat;
	} tag_t;

endpackage

### rtl/rti_tri_if.sv
interface rti_tri_if #(parameter int COORD_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] vertex0_x;
	logic signed [COORD_WIDTH-1:0] vertex0_y;
	logic signed [COORD_WIDTH-1:0] vertex0_z;
	logic signed [COORD_WIDTH-1:0] vertex1_x;
	logic signed [COORD_WIDTH-1:0] vertex1_y;
	logic signed [COORD_WIDTH-1:0] vertex1_z;
	logic signed [COORD_WIDTH-1:0] vertex2_x;
	logic signed [COORD_WIDTH-1:0] vertex2_y;
	logic signed [COORD_WIDTH-1:0] vertex2_z;

	modport source (
		output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
		       vertex2_x, vertex2_y, vertex2_z,
		input  ready
	);
	modport sink (
		input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
		       vertex2_x, vertex2_y, vertex2_z,
		output ready
	);
endinterface

### rtl/rti_hit_if.sv
interface rti_hit_if #(parameter int COORD_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic signed [COORD_WIDTH-1:0] hit_x;
	logic signed [COORD_WIDTH-1:0] hit_y;
	logic signed [COORD_WIDTH-1:0] hit_z;
	logic        [COORD_WIDTH-2:0] hit_t;

	modport source (
		output valid, hit, hit_x, hit_y, hit_z, hit_t,
		input  ready
	);
	modport sink (
		input  valid, hit, hit_x, hit_y, hit_z, hit_t,
		output ready
	);
endinterface

### rtl/ray_triangle_intersect.sv
// Moller-Trumbore ray/triangle test, one triangle request per clock while the
// output buffer has room. The ray (start and end point, signed Q16.16) sits in
// six registers written through wr_en/wr_idx/wr_data; the user must write them
// only while the block is idle, which the block does not enforce. Each triangle
// request yields one result: hit, the hit point and t (unsigned Q15.16,
// saturating), all zero on a miss. The t divider takes one quotient bit per
// stage over COORD_WIDTH-1 stages. A two-entry output buffer keeps taking
// requests while a result waits, and a stall stops the whole pipeline without loss.
module ray_triangle_intersect #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  rti_pkg::reg_idx_t      wr_idx,
	input  logic [COORD_WIDTH-1:0] wr_data,
	rti_tri_if.sink                triangle,
	rti_hit_if.source              result
);

	localparam int W    = COORD_WIDTH;
	localparam int FW   = rti_pkg::FRAC_BITS;
	localparam int DW   = W + 1;
	localparam int XW   = 2 * DW + 1;
	localparam int TW   = DW + XW + 2;
	localparam int TW1  = TW + 1;
	localparam int QW   = W - 1;
	localparam int PW2  = 2 * DW;
	localparam int PW3  = DW + XW;
	localparam int HW   = DW + QW + 1;
	localparam int HW1  = HW + 1;
	localparam int NW   = TW + FW;
	localparam int CW   = TW + FW + QW;
	localparam int PKW  = 1 + 3 * W + QW;
	localparam logic signed [TW-1:0]  EPS_DET = $signed(TW'(rti_pkg::EPS_LSB)) <<< (2 * FW);
	localparam logic signed [HW1-1:0] PMAX    = $signed(HW1'({1'b0, {(W-1){1'b1}}}));
	localparam logic signed [HW1-1:0] PMIN    = -PMAX - HW1'(1);

	logic adv;

	// configuration
	logic [W-1:0]          cfg_q [rti_pkg::NUM_REGS];
	logic signed [DW-1:0]  org [3];
	logic signed [DW-1:0]  dir [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rti_pkg::NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (wr_en && (wr_idx < rti_pkg::reg_idx_t'(rti_pkg::NUM_REGS))) begin
			cfg_q[wr_idx] <= wr_data;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_ray
		localparam int RS = int'(rti_pkg::REG_START_X) + c;
		localparam int RE = int'(rti_pkg::REG_END_X) + c;
		logic signed [DW-1:0] diff;

		assign org[c] = {cfg_q[RS][W-1], cfg_q[RS]};
		assign diff   = {cfg_q[RE][W-1], cfg_q[RE]} - org[c];
		assign dir[c] = (diff == '0) ? DW'(rti_pkg::EPS_LSB) : diff;
	end

	// stage 1: edges and origin offset
	logic [W-1:0]         vtx [3][3];
	logic signed [DW-1:0] e1_s1 [3], e2_s1 [3], s_s1 [3];
	logic signed [DW-1:0] e1_s2 [3], e2_s2 [3], s_s2 [3];
	logic signed [DW-1:0] e1_s3 [3], e2_s3 [3], s_s3 [3];
	logic signed [DW-1:0] e1_s4 [3], e2_s4 [3], s_s4 [3];
	logic signed [XW-1:0] h_s4 [3], q_s4 [3];
	logic signed [PW3-1:0] pd [3], pu [3], pv [3], pt [3];
	logic signed [TW-1:0] det_s7, u_s7, v_s7, t_s7;
	logic signed [TW-1:0] det_s8, u_s8, v_s8, t_s8;
	logic                 par_s8;
	logic [TW-1:0]        rem_s9, den_s9;
	logic [QW-1:0]        nlo_s9;
	logic                 miss_s9, sat_s9;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	assign vtx[0][0] = triangle.vertex0_x;
	assign vtx[0][1] = triangle.vertex0_y;
	assign vtx[0][2] = triangle.vertex0_z;
	assign vtx[1][0] = triangle.vertex1_x;
	assign vtx[1][1] = triangle.vertex1_y;
	assign vtx[1][2] = triangle.vertex1_z;
	assign vtx[2][0] = triangle.vertex2_x;
	assign vtx[2][1] = triangle.vertex2_y;
	assign vtx[2][2] = triangle.vertex2_z;

	assign triangle.ready = adv;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				e1_s1[c] <= {vtx[1][c][W-1], vtx[1][c]} - {vtx[0][c][W-1], vtx[0][c]};
				e2_s1[c] <= {vtx[2][c][W-1], vtx[2][c]} - {vtx[0][c][W-1], vtx[0][c]};
				s_s1[c]  <= org[c] - {vtx[0][c][W-1], vtx[0][c]};
				e1_s2[c] <= e1_s1[c];
				e2_s2[c] <= e2_s1[c];
				s_s2[c]  <= s_s1[c];
				e1_s3[c] <= e1_s2[c];
				e2_s3[c] <= e2_s2[c];
				s_s3[c]  <= s_s2[c];
				e1_s4[c] <= e1_s3[c];
				e2_s4[c] <= e2_s3[c];
				s_s4[c]  <= s_s3[c];
			end
		end
	end

	// stages 2-4: cross products h = dir x e2, q = s x e1
	for (genvar c = 0; c < 3; c++) begin : g_cross
		localparam int I1 = (c + 1) % 3;
		localparam int I2 = (c + 2) % 3;
		logic signed [PW2-1:0] hp_a, hp_b, qp_a, qp_b;

		rti_mul #(.AW(DW), .BW(DW)) u_ha (.clk, .en(adv), .a(dir[I1]), .b(e2_s1[I2]), .p(hp_a));
		rti_mul #(.AW(DW), .BW(DW)) u_hb (.clk, .en(adv), .a(dir[I2]), .b(e2_s1[I1]), .p(hp_b));
		rti_mul #(.AW(DW), .BW(DW)) u_qa (.clk, .en(adv), .a(s_s1[I1]), .b(e1_s1[I2]), .p(qp_a));
		rti_mul #(.AW(DW), .BW(DW)) u_qb (.clk, .en(adv), .a(s_s1[I2]), .b(e1_s1[I1]), .p(qp_b));

		always_ff @(posedge clk) begin
			if (adv) begin
				h_s4[c] <= XW'(hp_a) - XW'(hp_b);
				q_s4[c] <= XW'(qp_a) - XW'(qp_b);
			end
		end
	end

	// stages 5-7: det = e1.h, U = s.h, V = dir.q, T = e2.q
	for (genvar c = 0; c < 3; c++) begin : g_dot
		rti_mul #(.AW(DW), .BW(XW)) u_d (.clk, .en(adv), .a(e1_s4[c]), .b(h_s4[c]), .p(pd[c]));
		rti_mul #(.AW(DW), .BW(XW)) u_u (.clk, .en(adv), .a(s_s4[c]), .b(h_s4[c]), .p(pu[c]));
		rti_mul #(.AW(DW), .BW(XW)) u_v (.clk, .en(adv), .a(dir[c]), .b(q_s4[c]), .p(pv[c]));
		rti_mul #(.AW(DW), .BW(XW)) u_t (.clk, .en(adv), .a(e2_s4[c]), .b(q_s4[c]), .p(pt[c]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s7 <= TW'(pd[0]) + TW'(pd[1]) + TW'(pd[2]);
			u_s7   <= TW'(pu[0]) + TW'(pu[1]) + TW'(pu[2]);
			v_s7   <= TW'(pv[0]) + TW'(pv[1]) + TW'(pv[2]);
			t_s7   <= TW'(pt[0]) + TW'(pt[1]) + TW'(pt[2]);
		end
	end

	// stage 8: fold the sign of det
	always_ff @(posedge clk) begin
		if (adv) begin
			par_s8 <= (det_s7 > -EPS_DET) && (det_s7 < EPS_DET);
			det_s8 <= det_s7[TW-1] ? -det_s7 : det_s7;
			u_s8   <= det_s7[TW-1] ? -u_s7 : u_s7;
			v_s8   <= det_s7[TW-1] ? -v_s7 : v_s7;
			t_s8   <= det_s7[TW-1] ? -t_s7 : t_s7;
		end
	end

	// stage 9: range tests, saturation and divider seed
	logic signed [TW1-1:0] uv;
	logic        [NW-1:0]  num;

	assign uv  = TW1'(u_s8) + TW1'(v_s8);
	assign num = {t_s8, {FW{1'b0}}};

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s9 <= par_s8 || u_s8[TW-1] || (u_s8 > det_s8) || v_s8[TW-1]
				|| (uv > TW1'(det_s8)) || (t_s8 <= 0);
			sat_s9  <= CW'(num) >= CW'({det_s8, {QW{1'b0}}});
			rem_s9  <= TW'(num >> QW);
			nlo_s9  <= num[QW-1:0];
			den_s9  <= det_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= triangle.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// divider: t = floor(T * 2^16 / det)
	rti_pkg::tag_t tag_s9, tag_d, tag_s10, tag_s11;
	logic [QW-1:0] quo_d, tq, tq_s10, tq_s11;

	assign tag_s9 = '{valid: vld_s9, miss: miss_s9, sat: sat_s9};

	rti_div #(.RW(TW), .QW(QW)) u_div (
		.clk,
		.arst_n,
		.en      (adv),
		.rem     (rem_s9),
		.den     (den_s9),
		.nlo     (nlo_s9),
		.tag_in  (tag_s9),
		.quo     (quo_d),
		.tag_out (tag_d)
	);

	assign tq = tag_d.sat ? {QW{1'b1}} : quo_d;

	// hit point: start + floor(dir * t / 2^16)
	logic signed [HW-1:0]  prod [3];
	logic signed [W-1:0]   pnt [3];

	for (genvar c = 0; c < 3; c++) begin : g_point
		logic signed [HW1-1:0] sum;

		rti_mul #(.AW(DW), .BW(QW + 1)) u_p (
			.clk, .en(adv), .a(dir[c]), .b($signed({1'b0, tq})), .p(prod[c])
		);

		assign sum = HW1'(org[c]) + HW1'(prod[c] >>> FW);

		always_comb begin
			priority if (sum > PMAX) begin
				pnt[c] = PMAX[W-1:0];
			end else if (sum < PMIN) begin
				pnt[c] = PMIN[W-1:0];
			end else begin
				pnt[c] = sum[W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tq_s10 <= tq;
			tq_s11 <= tq_s10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s10 <= '0;
			tag_s11 <= '0;
		end else if (adv) begin
			tag_s10 <= tag_d;
			tag_s11 <= tag_s10;
		end
	end

	// output buffer
	logic [PKW-1:0] pack, dout;
	logic           full;

	assign pack = tag_s11.miss ? '0 : {1'b1, pnt[0], pnt[1], pnt[2], tq_s11};
	assign adv  = !full;

	rti_obuf #(.DW(PKW)) u_obuf (
		.clk,
		.arst_n,
		.push  (tag_s11.valid && adv),
		.din   (pack),
		.full  (full),
		.valid (result.valid),
		.ready (result.ready),
		.dout  (dout)
	);

	assign result.hit   = dout[PKW-1];
	assign result.hit_x = dout[QW+3*W-1 -: W];
	assign result.hit_y = dout[QW+2*W-1 -: W];
	assign result.hit_z = dout[QW+W-1 -: W];
	assign result.hit_t = dout[QW-1:0];

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.hit |-> result.hit_x == '0 && result.hit_y == '0
			&& result.hit_z == '0 && result.hit_t == '0)
		else $error("miss result carries nonzero fields");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s9) && $stable(tag_s11))
		else $error("pipeline moved while stalled");
	a_hit_not_parallel: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 && adv && !miss_s9 |-> den_s9 != '0)
		else $error("hit with zero determinant");
`endif

endmodule

### rtl/rti_mul.sv
module rti_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);

	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic signed [AH-1:0]    ah;
	logic        [AL-1:0]    al;
	logic signed [BH-1:0]    bh;
	logic        [BL-1:0]    bl;
	logic signed [AH+BH-1:0] hh_s1;
	logic signed [AH+BL:0]   hl_s1;
	logic signed [AL+BH:0]   lh_s1;
	logic        [AL+BL-1:0] ll_s1;
	logic signed [PW-1:0]    thh;
	logic signed [PW-1:0]    thl;
	logic signed [PW-1:0]    tlh;
	logic signed [PW-1:0]    tll;
	logic signed [PW-1:0]    p_s2;

	assign ah = a[AW-1:AL];
	assign al = a[AL-1:0];
	assign bh = b[BW-1:BL];
	assign bl = b[BL-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= ah * bh;
			hl_s1 <= ah * $signed({1'b0, bl});
			lh_s1 <= $signed({1'b0, al}) * bh;
			ll_s1 <= al * bl;
		end
	end

	assign thh = PW'(hh_s1);
	assign thl = PW'(hl_s1);
	assign tlh = PW'(lh_s1);
	assign tll = $signed(PW'(ll_s1));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= (thh <<< (AL + BL)) + (thl <<< AL) + (tlh <<< BL) + tll;
		end
	end

	assign p = p_s2;

endmodule

### rtl/rti_div.sv
module rti_div #(
	parameter int RW = 102,
	parameter int QW = 31
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [RW-1:0]  rem,
	input  logic [RW-1:0]  den,
	input  logic [QW-1:0]  nlo,
	input  rti_pkg::tag_t  tag_in,
	output logic [QW-1:0]  quo,
	output rti_pkg::tag_t  tag_out
);

	logic [RW-1:0]  rem_s [QW+1];
	logic [RW-1:0]  den_s [QW+1];
	logic [QW-1:0]  nlo_s [QW+1];
	logic [QW-1:0]  quo_s [QW+1];
	rti_pkg::tag_t  tag_s [QW+1];

	assign rem_s[0] = rem;
	assign den_s[0] = den;
	assign nlo_s[0] = nlo;
	assign quo_s[0] = '0;
	assign tag_s[0] = tag_in;

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int B = QW - 1 - k;
		logic [RW:0]   trial;
		logic [RW+1:0] diff;
		logic          borrow;
		logic [QW-1:0] q_next;

		assign trial  = {rem_s[k], nlo_s[k][B]};
		assign diff   = {1'b0, trial} - {2'b00, den_s[k]};
		assign borrow = diff[RW+1];

		always_comb begin
			q_next    = quo_s[k];
			q_next[B] = !borrow;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= borrow ? trial[RW-1:0] : diff[RW-1:0];
				den_s[k+1] <= den_s[k];
				nlo_s[k+1] <= nlo_s[k];
				quo_s[k+1] <= q_next;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (en) begin
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign quo     = quo_s[QW];
	assign tag_out = tag_s[QW];

`ifndef SYNTHESIS
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s[QW].valid && !tag_s[QW].miss && !tag_s[QW].sat |-> rem_s[QW] < den_s[QW])
		else $error("division remainder not below divisor");
`endif

endmodule

### rtl/rti_obuf.sv
module rti_obuf #(
	parameter int DW = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	output logic          full,
	output logic          valid,
	input  logic          ready,
	output logic [DW-1:0] dout
);

	logic [DW-1:0] ent_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign dout  = ent_q[rd_q];
	assign pop   = valid && ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q != 2'd2)
		else $error("output buffer overfilled");
`endif

endmodule
